@@ src/hse_pkg.sv @@
package hse_pkg;

  localparam int POS_W      = 24;
  localparam int COORD_W    = 32;
  localparam int VEC_W      = 3 * COORD_W;
  localparam int CNT_W      = 9;
  localparam int MAX_ADDR_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;

  localparam logic [1:0] KIND_LOAD_POINT   = 2'd0;
  localparam logic [1:0] KIND_LOAD_TANGENT = 2'd1;
  localparam logic [1:0] KIND_EVAL         = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TANGENT_COUNT = 1'd1;

  localparam int MIN_POINTS   = 3;
  localparam int MIN_TANGENTS = 2;
  localparam int SEG_SPAN     = 2;

  localparam logic [3:0] MAC_LAST  = 4'd11;
  localparam logic [3:0] MAC_END   = 4'd13;
  localparam logic [1:0] TERM_LAST = 2'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_RANGE = 2'd2
  } hse_status_t;

  typedef enum logic [1:0] {
    OP_LOAD_POINT,
    OP_LOAD_TANGENT,
    OP_EVAL
  } hse_op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQ,
    BK_CUBE,
    BK_BASIS,
    BK_MAC,
    BK_OUT
  } hse_bk_state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [23:0]        position;
  } hse_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [1:0]         status;
  } hse_out_t;

  typedef struct packed {
    hse_op_t                 op;
    hse_status_t             status;
    logic [MAX_ADDR_W-1:0]   addr;
    logic [POS_W-1:0]        position;
    logic [VEC_W-1:0]        vec;
  } hse_cmd_t;

endpackage

@@ src/hse_ram.sv @@
module hse_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ src/hse_front.sv @@
module hse_front #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  hse_pkg::hse_in_t               in_data,
  input  logic                           q_full,
  output logic                           q_push,
  output hse_pkg::hse_cmd_t              q_cmd,
  input  logic                           cfg_we,
  input  logic [hse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hse_pkg::CNT_W-1:0]      cfg_wdata
);

  localparam int CMP_W = hse_pkg::POS_W + 1;
  localparam logic [CMP_W-1:0] MAXP = CMP_W'(MAX_POINTS);

  logic [hse_pkg::CNT_W-1:0] point_cnt_r;
  logic [hse_pkg::CNT_W-1:0] tangent_cnt_r;
  logic [CMP_W-1:0]          np;
  logic [CMP_W-1:0]          nt;
  logic [CMP_W-1:0]          seg;
  logic [CMP_W-1:0]          seg_end;
  logic [CMP_W-1:0]          slot_w;
  logic                      keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_cnt_r   <= '0;
      tangent_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hse_pkg::CFG_POINT_COUNT:   point_cnt_r   <= cfg_wdata;
        hse_pkg::CFG_TANGENT_COUNT: tangent_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    np      = (CMP_W'(point_cnt_r) > MAXP) ? MAXP : CMP_W'(point_cnt_r);
    nt      = (CMP_W'(tangent_cnt_r) > MAXP) ? MAXP : CMP_W'(tangent_cnt_r);
    seg     = CMP_W'(in_data.position >> FRAC_BITS);
    seg_end = seg + CMP_W'(hse_pkg::SEG_SPAN);
    slot_w  = CMP_W'(in_data.slot);

    q_cmd.position = in_data.position;
    q_cmd.vec      = {in_data.coord_z, in_data.coord_y, in_data.coord_x};
    q_cmd.addr     = hse_pkg::MAX_ADDR_W'(in_data.slot);
    q_cmd.status   = hse_pkg::ST_OK;
    q_cmd.op       = hse_pkg::OP_EVAL;
    keep           = 1'b0;

    case (in_data.kind)
      hse_pkg::KIND_LOAD_POINT: begin
        q_cmd.op = hse_pkg::OP_LOAD_POINT;
        keep     = slot_w < MAXP;
      end
      hse_pkg::KIND_LOAD_TANGENT: begin
        q_cmd.op = hse_pkg::OP_LOAD_TANGENT;
        keep     = slot_w < MAXP;
      end
      hse_pkg::KIND_EVAL: begin
        keep       = 1'b1;
        q_cmd.addr = seg[hse_pkg::MAX_ADDR_W-1:0];
        if (np < CMP_W'(hse_pkg::MIN_POINTS) || nt < CMP_W'(hse_pkg::MIN_TANGENTS)) begin
          q_cmd.status = hse_pkg::ST_FEW;
        end else if (seg_end > np || seg_end > nt) begin
          q_cmd.status = hse_pkg::ST_RANGE;
        end
      end
      default: keep = 1'b0;
    endcase

    q_push = in_push && !q_full && keep;
  end

endmodule

@@ src/hse_cmd_q.sv @@
module hse_cmd_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hse_pkg::hse_cmd_t cmd_in,
  output logic              full,
  input  logic              pop,
  output hse_pkg::hse_cmd_t cmd_out,
  output logic              empty
);

  hse_pkg::hse_cmd_t           entry_r [hse_pkg::CMDQ_DEPTH];
  logic [hse_pkg::CMDQ_AW-1:0] wr_ptr_r;
  logic [hse_pkg::CMDQ_AW-1:0] rd_ptr_r;
  logic [hse_pkg::CMDQ_AW:0]   cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign full    = cnt_r == (hse_pkg::CMDQ_AW + 1)'(hse_pkg::CMDQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue count did not follow a lone push");

endmodule

@@ src/hse_back.sv @@
module hse_back #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  hse_pkg::hse_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output hse_pkg::hse_out_t out_data
);

  localparam int F     = FRAC_BITS;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int H_W   = F + 3;
  localparam int P_W   = hse_pkg::COORD_W + H_W;
  localparam int ACC_W = P_W + 2;
  localparam int SH_W  = ACC_W - F;

  localparam logic [2*F:0] HALF_SQ = (2*F+1)'(1) << (F - 1);
  localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) << (F - 1);
  localparam logic signed [H_W-1:0] ONE_H = {3'b001, {F{1'b0}}};

  hse_pkg::hse_bk_state_t state_r;
  hse_pkg::hse_bk_state_t state_nxt;

  logic p_we;
  logic t_we;
  logic rd_en;
  logic load_out;
  logic issue;

  logic [hse_pkg::VEC_W-1:0] p0;
  logic [hse_pkg::VEC_W-1:0] p1;
  logic [hse_pkg::VEC_W-1:0] t0;
  logic [hse_pkg::VEC_W-1:0] t1;
  logic [AW-1:0]             addr_a;
  logic [AW-1:0]             addr_b;

  logic [F-1:0]   w_r;
  logic [F-1:0]   sq_r;
  logic [F-1:0]   cube_r;
  logic [2*F-1:0] sq_prod;
  logic [2*F-1:0] cube_prod;
  logic [2*F:0]   sq_rnd;
  logic [2*F:0]   cube_rnd;

  logic signed [H_W-1:0] e1;
  logic signed [H_W-1:0] e2;
  logic signed [H_W-1:0] e3;
  logic signed [H_W-1:0] h_nxt [4];
  logic signed [H_W-1:0] h_r   [4];

  logic [3:0]                      idx_r;
  logic [hse_pkg::VEC_W-1:0]       mul_vec;
  logic signed [hse_pkg::COORD_W-1:0] mul_op;
  logic signed [P_W-1:0]           prod_nxt;
  logic signed [P_W-1:0]           prod_r;
  logic                            mac_v_r;
  logic [1:0]                      mac_term_r;
  logic [1:0]                      mac_coord_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic                            fin_v_r;
  logic [1:0]                      fin_coord_r;
  logic signed [SH_W-1:0]          sh;
  logic [SH_W-32:0]                sh_top;
  logic [31:0]                     sat;

  logic [31:0]          res_x_r;
  logic [31:0]          res_y_r;
  logic [31:0]          res_z_r;
  hse_pkg::hse_status_t st_r;
  logic                 out_v_r;
  hse_pkg::hse_out_t    out_data_r;

  assign addr_a = q_cmd.addr[AW-1:0];
  assign addr_b = addr_a + 1'b1;

  hse_ram #(.WIDTH(hse_pkg::VEC_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk     (clk),
    .we      (p_we),
    .waddr   (addr_a),
    .wdata   (q_cmd.vec),
    .re      (rd_en),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (p0),
    .rdata_b (p1)
  );

  hse_ram #(.WIDTH(hse_pkg::VEC_W), .DEPTH(MAX_POINTS)) u_tangent_ram (
    .clk     (clk),
    .we      (t_we),
    .waddr   (addr_a),
    .wdata   (q_cmd.vec),
    .re      (rd_en),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (t0),
    .rdata_b (t1)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    p_we      = 1'b0;
    t_we      = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      hse_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            hse_pkg::OP_LOAD_POINT:   p_we = 1'b1;
            hse_pkg::OP_LOAD_TANGENT: t_we = 1'b1;
            hse_pkg::OP_EVAL: begin
              if (q_cmd.status == hse_pkg::ST_OK) begin
                rd_en     = 1'b1;
                state_nxt = hse_pkg::BK_SQ;
              end else begin
                state_nxt = hse_pkg::BK_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      hse_pkg::BK_SQ:    state_nxt = hse_pkg::BK_CUBE;
      hse_pkg::BK_CUBE:  state_nxt = hse_pkg::BK_BASIS;
      hse_pkg::BK_BASIS: state_nxt = hse_pkg::BK_MAC;
      hse_pkg::BK_MAC: begin
        if (idx_r == hse_pkg::MAC_END) begin
          state_nxt = hse_pkg::BK_OUT;
        end
      end
      hse_pkg::BK_OUT: begin
        if (!out_v_r || out_pop) begin
          load_out  = 1'b1;
          state_nxt = hse_pkg::BK_IDLE;
        end
      end
      default: state_nxt = hse_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    sq_prod   = w_r * w_r;
    sq_rnd    = {1'b0, sq_prod} + HALF_SQ;
    cube_prod = sq_r * w_r;
    cube_rnd  = {1'b0, cube_prod} + HALF_SQ;

    e1 = $signed({3'b000, w_r});
    e2 = $signed({3'b000, sq_r});
    e3 = $signed({3'b000, cube_r});
    h_nxt[0] = (e3 <<< 1) - e2 - (e2 <<< 1) + ONE_H;
    h_nxt[1] = e2 + (e2 <<< 1) - (e3 <<< 1);
    h_nxt[2] = e3 - (e2 <<< 1) + e1;
    h_nxt[3] = e3 - e2;
  end

  always_comb begin
    issue = (state_r == hse_pkg::BK_MAC) && (idx_r <= hse_pkg::MAC_LAST);
    case (idx_r[1:0])
      2'd0:    mul_vec = p0;
      2'd1:    mul_vec = p1;
      2'd2:    mul_vec = t0;
      default: mul_vec = t1;
    endcase
    case (idx_r[3:2])
      2'd0:    mul_op = $signed(mul_vec[31:0]);
      2'd1:    mul_op = $signed(mul_vec[63:32]);
      2'd2:    mul_op = $signed(mul_vec[95:64]);
      default: mul_op = '0;
    endcase
    prod_nxt = mul_op * h_r[idx_r[1:0]];

    sh     = acc_r[ACC_W-1:F];
    sh_top = sh[SH_W-1:31];
    if ((&sh_top) || !(|sh_top)) begin
      sat = sh[31:0];
    end else if (sh[SH_W-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hse_pkg::BK_IDLE && !q_empty && q_cmd.op == hse_pkg::OP_EVAL) begin
      w_r     <= q_cmd.position[F-1:0];
      st_r    <= q_cmd.status;
      res_x_r <= '0;
      res_y_r <= '0;
      res_z_r <= '0;
    end
    if (state_r == hse_pkg::BK_SQ) begin
      sq_r <= sq_rnd[2*F-1:F];
    end
    if (state_r == hse_pkg::BK_CUBE) begin
      cube_r <= cube_rnd[2*F-1:F];
    end
    if (state_r == hse_pkg::BK_BASIS) begin
      h_r <= h_nxt;
    end
    if (issue) begin
      prod_r      <= prod_nxt;
      mac_term_r  <= idx_r[1:0];
      mac_coord_r <= idx_r[3:2];
    end
    if (mac_v_r) begin
      if (mac_term_r == 2'd0) begin
        acc_r <= ACC_W'(prod_r) + HALF_A;
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      fin_coord_r <= mac_coord_r;
    end
    if (fin_v_r) begin
      case (fin_coord_r)
        2'd0:    res_x_r <= sat;
        2'd1:    res_y_r <= sat;
        default: res_z_r <= sat;
      endcase
    end
    if (load_out) begin
      out_data_r.point_x <= $signed(res_x_r);
      out_data_r.point_y <= $signed(res_y_r);
      out_data_r.point_z <= $signed(res_z_r);
      out_data_r.status  <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hse_pkg::BK_IDLE;
      idx_r   <= '0;
      mac_v_r <= 1'b0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hse_pkg::BK_BASIS) begin
        idx_r <= '0;
      end else if (state_r == hse_pkg::BK_MAC) begin
        idx_r <= idx_r + 1'b1;
      end
      mac_v_r <= issue;
      fin_v_r <= mac_v_r && (mac_term_r == hse_pkg::TERM_LAST);
      if (out_pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end
    end
  end

  assign out_empty = !out_v_r;
  assign out_data  = out_data_r;

  a_fin_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r |-> (state_r == hse_pkg::BK_MAC))
    else $error("coordinate finished outside the accumulate phase");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hse_pkg::BK_OUT && out_v_r && !out_pop)
      |=> (state_r == hse_pkg::BK_OUT && out_v_r))
    else $error("pending result overwritten while the output stalled");

  a_read_before_sq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hse_pkg::BK_SQ) |-> ($past(rd_en)))
    else $error("evaluation started without a table read");

endmodule

@@ src/hermite_spline_evaluator.sv @@
// Cubic Hermite spline evaluator over tables of 3D points and tangents.
// Requests enter through a queue-style port: a request is taken at a rising
// edge with in_push high and in_full low. A load request writes one point or
// tangent entry; an evaluate request yields one result on the output side.
// Results leave through a queue-style port: out_data is valid while out_empty
// is low and is taken at a rising edge with out_pop high.
// The user writes the point and tangent counts through cfg_we, cfg_index and
// cfg_wdata while no request is in flight; the block does not enforce it.
// A request that passes the input check sits in a two-entry command queue,
// so new requests are taken while a result waits for out_pop.
// A load is written to its table as the engine pops it from the queue. An
// evaluate request with valid counts and segment steps through the engine
// in order: the table read, the squared weight, the cubed weight, the basis,
// twelve products through a single shared multiplier followed by accumulate
// and saturate, and the load of the output register, which waits while an
// earlier result is still unread. A rejected evaluate goes straight to the
// output register load.
// While out_pop stays low the engine holds its finished result, the command
// queue fills and in_full rises. Reset clears the counts, the queue and the
// output; table contents are not cleared and must be loaded before use.
module hermite_spline_evaluator #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  hse_pkg::hse_in_t              in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output hse_pkg::hse_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [hse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hse_pkg::CNT_W-1:0]     cfg_wdata
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  hse_pkg::hse_cmd_t q_cmd_in;
  hse_pkg::hse_cmd_t q_cmd_out;

  assign in_full = q_full;

  hse_front #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hse_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (q_cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (q_cmd_out),
    .empty   (q_empty)
  );

  hse_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
